// ===== src/triangle_plane_slice_defines.svh =====
// Assertion macros for the triangle plane slice block.
// No dependencies; included by the top level only.
`ifndef TRIANGLE_PLANE_SLICE_DEFINES_SVH
`define TRIANGLE_PLANE_SLICE_DEFINES_SVH

`ifndef SYNTHESIS
`define TPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tps assertion failed");
`define TPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tps assertion failed");
`else
`define TPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== src/tps_pkg.sv =====
// Shared types, sizes and vertex selection for the triangle plane slice.
// No dependencies.
package tps_pkg;

  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned STEP_CNT = 36;
  localparam int unsigned STG_STEPS = 4;
  localparam int unsigned DIV_STGS = STEP_CNT / STG_STEPS;
  localparam int unsigned REM_W    = DIFF_W + 1;
  localparam int unsigned LANES    = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [2:0] vtx3_t;

  // one output coordinate in flight
  typedef struct packed {
    coord_t              lc;
    logic [DIFF_W-1:0]   dmag;
    logic [DIFF_W-1:0]   nmag;
    logic [DIFF_W-1:0]   den;
    logic                neg;
  } lane_t;

  typedef struct packed {
    coord_t              lc;
    logic [DIFF_W-1:0]   den;
    logic                neg;
    logic [REM_W-1:0]    rem;
    logic [STEP_CNT-1:0] dvd;
    logic [STEP_CNT-1:0] quo;
  } div_t;

  typedef lane_t [LANES-1:0] lanes_t;
  typedef div_t  [LANES-1:0] divs_t;

  function automatic logic [1:0] lone_sel(input logic [2:0] m);
    unique case (m)
      3'd1, 3'd6: lone_sel = 2'd0;
      3'd2, 3'd5: lone_sel = 2'd1;
      3'd3, 3'd4: lone_sel = 2'd2;
      default:    lone_sel = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] first_sel(input logic [2:0] m);
    unique case (m)
      3'd1, 3'd6: first_sel = 2'd1;
      3'd5:       first_sel = 2'd2;
      default:    first_sel = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] second_sel(input logic [2:0] m);
    unique case (m)
      3'd1, 3'd2, 3'd6: second_sel = 2'd2;
      3'd3, 3'd4:       second_sel = 2'd1;
      default:          second_sel = 2'd0;
    endcase
  endfunction

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

endpackage

// ===== src/tps_in_if.sv =====
// Input channel: one triangle and a plane height per transaction.
// Depends on tps_pkg.
interface tps_in_if;
  logic            valid;
  logic            ready;
  tps_pkg::coord_t v1_x, v1_y, v1_z;
  tps_pkg::coord_t v2_x, v2_y, v2_z;
  tps_pkg::coord_t v3_x, v3_y, v3_z;
  tps_pkg::coord_t plane_z;

  modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  v3_x, v3_y, v3_z, plane_z, input ready);
  modport sink   (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                  v3_x, v3_y, v3_z, plane_z, output ready);
endinterface

// ===== src/tps_out_if.sv =====
// Output channel: hit flag and segment endpoints per transaction.
// Depends on tps_pkg.
interface tps_out_if;
  logic            valid;
  logic            ready;
  logic            hit;
  tps_pkg::coord_t start_x, start_y, end_x, end_y;

  modport source (output valid, hit, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, hit, start_x, start_y, end_x, end_y, output ready);
endinterface

// ===== src/tps_prep.sv =====
// First stage: above mask, lone/other vertex pick, differences and magnitudes.
// Depends on tps_pkg.
module tps_prep (
  input  logic            clk_i,
  input  logic            en_i,
  input  tps_pkg::vtx3_t  x_i,
  input  tps_pkg::vtx3_t  y_i,
  input  tps_pkg::vtx3_t  z_i,
  input  tps_pkg::coord_t pz_i,
  output logic            hit_o,
  output tps_pkg::lanes_t lanes_o
);
  import tps_pkg::*;

  logic [2:0]  above;
  logic [1:0]  li, ai, bi;
  lanes_t      lanes_d, lanes_q;
  logic        hit_d, hit_q;

  always_comb begin
    logic [1:0]               oi;
    coord_t                   lc, oc;
    logic signed [DIFF_W-1:0] d, n, den;
    for (int k = 0; k < 3; k++) above[k] = z_i[k] > pz_i;
    li = lone_sel(above);
    ai = first_sel(above);
    bi = second_sel(above);
    hit_d = (above != 3'd0) && (above != 3'd7);
    for (int l = 0; l < LANES; l++) begin
      oi  = (l < 2) ? ai : bi;
      lc  = (l % 2 == 0) ? x_i[li] : y_i[li];
      oc  = (l % 2 == 0) ? x_i[oi] : y_i[oi];
      d   = DIFF_W'(oc) - DIFF_W'(lc);
      n   = DIFF_W'(pz_i) - DIFF_W'(z_i[li]);
      den = DIFF_W'(z_i[oi]) - DIFF_W'(z_i[li]);
      lanes_d[l].lc   = lc;
      lanes_d[l].dmag = mag(d);
      lanes_d[l].nmag = mag(n);
      lanes_d[l].den  = mag(den);
      lanes_d[l].neg  = d[DIFF_W-1] ^ n[DIFF_W-1] ^ den[DIFF_W-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lanes_q <= lanes_d;
      hit_q   <= hit_d;
    end
  end

  assign lanes_o = lanes_q;
  assign hit_o   = hit_q;
endmodule

// ===== src/tps_mul.sv =====
// Product stage: |d| * |n| per lane, loads the divider's initial state.
// Depends on tps_pkg.
module tps_mul (
  input  logic            clk_i,
  input  logic            en_i,
  input  tps_pkg::lanes_t lanes_i,
  output tps_pkg::divs_t  divs_o
);
  import tps_pkg::*;

  divs_t divs_d, divs_q;

  always_comb begin
    logic [PROD_W-1:0] p;
    for (int l = 0; l < LANES; l++) begin
      p = PROD_W'(lanes_i[l].dmag) * PROD_W'(lanes_i[l].nmag);
      divs_d[l].lc  = lanes_i[l].lc;
      divs_d[l].den = lanes_i[l].den;
      divs_d[l].neg = lanes_i[l].neg;
      // quotient is below 2^33, so the high part is already below den
      divs_d[l].rem = REM_W'(p[PROD_W-1:STEP_CNT]);
      divs_d[l].dvd = p[STEP_CNT-1:0];
      divs_d[l].quo = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) divs_q <= divs_d;
  end

  assign divs_o = divs_q;
endmodule

// ===== src/tps_div_stage.sv =====
// One restoring-division stage: STG_STEPS quotient bits for every lane.
// Depends on tps_pkg.
module tps_div_stage (
  input  logic           clk_i,
  input  logic           en_i,
  input  tps_pkg::divs_t divs_i,
  output tps_pkg::divs_t divs_o
);
  import tps_pkg::*;

  divs_t divs_d, divs_q;

  always_comb begin
    logic [REM_W-1:0] r2;
    logic             ge;
    divs_d = divs_i;
    for (int l = 0; l < LANES; l++) begin
      for (int s = 0; s < STG_STEPS; s++) begin
        r2 = {divs_d[l].rem[REM_W-2:0], divs_d[l].dvd[STEP_CNT-1]};
        ge = r2 >= {1'b0, divs_d[l].den};
        divs_d[l].rem = ge ? r2 - {1'b0, divs_d[l].den} : r2;
        divs_d[l].quo = {divs_d[l].quo[STEP_CNT-2:0], ge};
        divs_d[l].dvd = {divs_d[l].dvd[STEP_CNT-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) divs_q <= divs_d;
  end

  assign divs_o = divs_q;
endmodule

// ===== src/triangle_plane_slice.sv =====
// Triangle/plane intersection, top level.
// Depends on tps_pkg, tps_in_if, tps_out_if, tps_prep, tps_mul, tps_div_stage.

// Cuts one triangle with a horizontal plane per transaction and returns the
// crossing segment's endpoints, or hit = 0 with zero endpoints when the
// plane misses. Fully pipelined: a new triangle can be accepted every
// cycle while the output is not stalled, and each result passes through
// prep, multiply, nine 4-bit restoring-division stages and the output
// register. The whole pipeline advances together; it holds only when the
// output register is full and not taken.
`include "triangle_plane_slice_defines.svh"

module triangle_plane_slice (
  input  logic      clk_i,
  input  logic      rst_ni,
  tps_in_if.sink    in_i,
  tps_out_if.source out_o
);
  import tps_pkg::*;

  localparam int unsigned NSTG = DIV_STGS + 3;

  logic              en;
  logic [NSTG-1:0]   vld_q;
  logic [NSTG-3:0]   hit_q;       // hit flag riding beside stages 1..NSTG-2
  logic              hit_p;
  vtx3_t             xs, ys, zs;
  lanes_t            lanes;
  divs_t             divs [DIV_STGS+1];
  logic              out_hit_d, out_hit_q;
  coord_t            res_d [LANES];
  coord_t            res_q [LANES];

  // single stall point: the output register
  assign en       = !vld_q[NSTG-1] || out_o.ready;
  assign in_i.ready = en;

  assign xs = {in_i.v3_x, in_i.v2_x, in_i.v1_x};
  assign ys = {in_i.v3_y, in_i.v2_y, in_i.v1_y};
  assign zs = {in_i.v3_z, in_i.v2_z, in_i.v1_z};

  tps_prep u_prep (
    .clk_i   (clk_i),
    .en_i    (en),
    .x_i     (xs),
    .y_i     (ys),
    .z_i     (zs),
    .pz_i    (in_i.plane_z),
    .hit_o   (hit_p),
    .lanes_o (lanes)
  );

  tps_mul u_mul (
    .clk_i   (clk_i),
    .en_i    (en),
    .lanes_i (lanes),
    .divs_o  (divs[0])
  );

  for (genvar g = 0; g < DIV_STGS; g++) begin : g_div
    tps_div_stage u_stg (
      .clk_i  (clk_i),
      .en_i   (en),
      .divs_i (divs[g]),
      .divs_o (divs[g+1])
    );
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTG-2:0], in_i.valid};
    end
  end

  // hit flag pipeline, aligned with the multiply and divider stages
  always_ff @(posedge clk_i) begin
    if (en) hit_q <= {hit_q[NSTG-4:0], hit_p};
  end

  // final add/subtract; truncation to the field wraps
  always_comb begin
    out_hit_d = hit_q[NSTG-3];
    for (int l = 0; l < LANES; l++) begin
      if (!out_hit_d) begin
        res_d[l] = '0;
      end else if (divs[DIV_STGS][l].neg) begin
        res_d[l] = divs[DIV_STGS][l].lc - coord_t'(divs[DIV_STGS][l].quo[COORD_W-1:0]);
      end else begin
        res_d[l] = divs[DIV_STGS][l].lc + coord_t'(divs[DIV_STGS][l].quo[COORD_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_hit_q <= out_hit_d;
      res_q     <= res_d;
    end
  end

  assign out_o.valid   = vld_q[NSTG-1];
  assign out_o.hit     = out_hit_q;
  assign out_o.start_x = res_q[0];
  assign out_o.start_y = res_q[1];
  assign out_o.end_x   = res_q[2];
  assign out_o.end_y   = res_q[3];

  // a miss always carries zero endpoints
  `TPS_ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, out_o.valid && !out_o.hit, out_o.start_x == 0 && out_o.end_x == 0 && out_o.start_y == 0 && out_o.end_y == 0)
  // an accepted transaction enters the first stage
  `TPS_ASSERT_NEXT(a_enter, clk_i, rst_ni, in_i.valid && in_i.ready, vld_q[0])
  // a held result keeps its stage-valid bits frozen behind it
  `TPS_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, $stable(vld_q))

endmodule
